// ----- rtl/dcrt_pkg.sv -----
// Package for the dual channel reload timer: register map, item kinds,
// control bit positions and the structs passed between top level and channels.
// No dependencies.
package dcrt_pkg;

   localparam int NUM_CHANNELS_DEF = 2;
   localparam int COUNT_WIDTH_DEF  = 32;
   localparam int DATA_W           = 32;
   localparam int ADDR_W           = 4;
   localparam int PRESCALE_W       = 7;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_IDLE  = 2'd3
   } kind_type;

   // word addresses of the shared registers
   localparam logic [ADDR_W-1:0] ADDR_IRQ_ENABLE = 4'd0;
   localparam logic [ADDR_W-1:0] ADDR_IRQ_STATUS = 4'd1;

   // word offsets within a channel slot
   localparam logic [1:0] OFF_CONTROL  = 2'd0;
   localparam logic [1:0] OFF_INTERVAL = 2'd1;
   localparam logic [1:0] OFF_CURRENT  = 2'd2;
   localparam logic [1:0] OFF_SPARE    = 2'd3;

   // control register bits
   localparam int CTL_EN_BIT     = 0;
   localparam int CTL_RELOAD_BIT = 1;
   localparam int CTL_FAST_BIT   = 2;
   localparam int CTL_PRE_LSB    = 4;
   localparam int CTL_PRE_MSB    = 6;
   localparam int CTL_SINGLE_BIT = 7;

   typedef struct packed {
      logic              tick;
      logic              pulse_fast;
      logic              pulse_slow;
      logic              wr_control;
      logic              wr_interval;
      logic              wr_current;
      logic [DATA_W-1:0] data;
   } chan_cmd_type;

   typedef struct packed {
      logic [7:0]        control;
      logic [DATA_W-1:0] interval;
      logic [DATA_W-1:0] current;
      logic              expire;
   } chan_stat_type;

endpackage

// ----- rtl/dcrt_channel.sv -----
// One timer channel: control, interval, current value and prescaler.
// Depends on dcrt_pkg.
module dcrt_channel import dcrt_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  chan_cmd_type  cmd,
   output chan_stat_type stat
);

   logic                   en_ff, en_in;
   logic                   fast_ff, fast_in;
   logic [2:0]             pre_ff, pre_in;
   logic                   single_ff, single_in;
   logic [COUNT_WIDTH-1:0] interval_ff, interval_in;
   logic [COUNT_WIDTH-1:0] current_ff, current_in;
   logic [PRESCALE_W-1:0]  count_ff, count_in;
   logic [PRESCALE_W-1:0]  limit;
   logic                   pulse;
   logic                   expire;

   // divide by 2^p: wrap once the count reaches 2^p - 1
   assign limit = ~({PRESCALE_W{1'b1}} << pre_ff);
   assign pulse = fast_ff ? cmd.pulse_fast : cmd.pulse_slow;

   always_comb begin
      en_in       = en_ff;
      fast_in     = fast_ff;
      pre_in      = pre_ff;
      single_in   = single_ff;
      interval_in = interval_ff;
      current_in  = current_ff;
      count_in    = count_ff;
      expire      = 1'b0;
      if (cmd.wr_control) begin
         en_in     = cmd.data[CTL_EN_BIT];
         fast_in   = cmd.data[CTL_FAST_BIT];
         pre_in    = cmd.data[CTL_PRE_MSB:CTL_PRE_LSB];
         single_in = cmd.data[CTL_SINGLE_BIT];
         if (cmd.data[CTL_RELOAD_BIT]) begin
            current_in = interval_ff;
            count_in   = '0;
         end
      end else if (cmd.wr_interval) begin
         interval_in = cmd.data[COUNT_WIDTH-1:0];
      end else if (cmd.wr_current) begin
         current_in = cmd.data[COUNT_WIDTH-1:0];
      end else if (cmd.tick && en_ff && pulse) begin
         if (count_ff < limit) begin
            count_in = count_ff + PRESCALE_W'(1);
         end else begin
            count_in = '0;
            if (current_ff != '0) begin
               current_in = current_ff - COUNT_WIDTH'(1);
            end else begin
               expire = 1'b1;
               if (single_ff) begin
                  en_in = 1'b0;
               end else begin
                  current_in = interval_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff       <= 1'b0;
         fast_ff     <= 1'b0;
         pre_ff      <= '0;
         single_ff   <= 1'b0;
         interval_ff <= '0;
         current_ff  <= '0;
         count_ff    <= '0;
      end else begin
         en_ff       <= en_in;
         fast_ff     <= fast_in;
         pre_ff      <= pre_in;
         single_ff   <= single_in;
         interval_ff <= interval_in;
         current_ff  <= current_in;
         count_ff    <= count_in;
      end
   end

   // reload and bit 3 always read back as zero
   assign stat.control  = {single_ff, pre_ff, 1'b0, fast_ff, 1'b0, en_ff};
   assign stat.interval = DATA_W'(interval_ff);
   assign stat.current  = DATA_W'(current_ff);
   assign stat.expire   = expire;

endmodule

// ----- rtl/dual_channel_reload_timer.sv -----
// Top level of the dual channel reload timer: input register, register map
// decode, interrupt registers and result register. Depends on dcrt_pkg, dcrt_channel.
//
//   port group   dir   content
//   req_*        in    tuser: kind; tdata: word_addr, write_data, pulse_fast, pulse_slow
//   rsp_*        out   tdata: read_data, irq_line
//
// One item per clock sustained while rsp_tready stays high; each item waits in the input
// register and is then executed against the timer state as it moves into the result
// register, whose content is offered on rsp_.
// Reset clears the timer state and the valid flags of both pipeline registers.
// With rsp_tready low the result is held; the input register takes one more item
// and then req_tready drops.
module dual_channel_reload_timer import dcrt_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // word_addr[3:0], write_data[35:4], pulse_fast[36],
                                   // pulse_slow[37], zero[39:38]
   input  logic [1:0]  req_tuser,  // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // read_data[31:0], irq_line[32], zero[39:33]
);

   logic                    in_valid_ff, in_valid_in;
   kind_type                kind_ff;
   logic [ADDR_W-1:0]       addr_ff;
   logic [DATA_W-1:0]       data_ff;
   logic                    fast_ff;
   logic                    slow_ff;

   logic                    out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]       read_data_ff, read_data_in;
   logic                    irq_ff, irq_in;

   logic [NUM_CHANNELS-1:0] irq_enable_ff, irq_enable_in;
   logic [NUM_CHANNELS-1:0] irq_pending_ff, irq_pending_in;

   logic                    advance;
   logic                    accept;
   logic                    do_tick, do_read, do_write;
   logic [NUM_CHANNELS-1:0] chan_hit;
   logic [NUM_CHANNELS-1:0] expire;
   logic [DATA_W-1:0]       chan_rd [NUM_CHANNELS];
   chan_cmd_type            cmd [NUM_CHANNELS];
   chan_stat_type           stat [NUM_CHANNELS];

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign do_tick  = advance && (kind_ff == KIND_TICK);
   assign do_read  = advance && (kind_ff == KIND_READ);
   assign do_write = advance && (kind_ff == KIND_WRITE);

   genvar c;
   generate
      for (c = 0; c < NUM_CHANNELS; c++) begin : g_chan
         // channel c occupies words 4c+4 .. 4c+7
         assign chan_hit[c] = (int'(addr_ff[3:2]) == c + 1);

         assign cmd[c].tick        = do_tick;
         assign cmd[c].pulse_fast  = fast_ff;
         assign cmd[c].pulse_slow  = slow_ff;
         assign cmd[c].wr_control  = do_write && chan_hit[c] && (addr_ff[1:0] == OFF_CONTROL);
         assign cmd[c].wr_interval = do_write && chan_hit[c] && (addr_ff[1:0] == OFF_INTERVAL);
         assign cmd[c].wr_current  = do_write && chan_hit[c] && (addr_ff[1:0] == OFF_CURRENT);
         assign cmd[c].data        = data_ff;

         dcrt_channel #(
            .COUNT_WIDTH(COUNT_WIDTH)
         ) u_channel (
            .clock(clock),
            .reset(reset),
            .cmd  (cmd[c]),
            .stat (stat[c])
         );

         assign expire[c] = stat[c].expire;

         always_comb begin
            chan_rd[c] = '0;
            if (chan_hit[c]) begin
               case (addr_ff[1:0])
                  OFF_CONTROL:  chan_rd[c] = DATA_W'(stat[c].control);
                  OFF_INTERVAL: chan_rd[c] = stat[c].interval;
                  OFF_CURRENT:  chan_rd[c] = stat[c].current;
                  default:      chan_rd[c] = '0;
               endcase
            end
         end
      end
   endgenerate

   // shared interrupt registers; status is write one to clear
   always_comb begin
      irq_enable_in  = irq_enable_ff;
      irq_pending_in = irq_pending_ff;
      if (do_tick) begin
         irq_pending_in = irq_pending_ff | expire;
      end else if (do_write && (addr_ff == ADDR_IRQ_ENABLE)) begin
         irq_enable_in = data_ff[NUM_CHANNELS-1:0];
      end else if (do_write && (addr_ff == ADDR_IRQ_STATUS)) begin
         irq_pending_in = irq_pending_ff & ~data_ff[NUM_CHANNELS-1:0];
      end
   end

   always_comb begin
      read_data_in = read_data_ff;
      irq_in       = irq_ff;
      if (advance) begin
         read_data_in = '0;
         irq_in       = |(irq_pending_in & irq_enable_in);
         if (do_read) begin
            if (addr_ff == ADDR_IRQ_ENABLE) begin
               read_data_in = DATA_W'(irq_enable_ff);
            end else if (addr_ff == ADDR_IRQ_STATUS) begin
               read_data_in = DATA_W'(irq_pending_ff);
            end else begin
               for (int i = 0; i < NUM_CHANNELS; i++) begin
                  read_data_in = read_data_in | chan_rd[i];
               end
            end
         end
      end
   end

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         irq_enable_ff  <= '0;
         irq_pending_ff <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         irq_enable_ff  <= irq_enable_in;
         irq_pending_ff <= irq_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_type'(req_tuser);
         addr_ff <= req_tdata[3:0];
         data_ff <= req_tdata[35:4];
         fast_ff <= req_tdata[36];
         slow_ff <= req_tdata[37];
      end
      read_data_ff <= read_data_in;
      irq_ff       <= irq_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, irq_ff, read_data_ff};

   // the held interrupt flag tracks the state, which only moves when a result is loaded
   a_irq_consistent: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (irq_ff == |(irq_pending_ff & irq_enable_ff)))
      else $error("irq flag out of step with interrupt state");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && (kind_ff != KIND_READ)) |=> (read_data_ff == '0))
      else $error("read data non-zero for an item that is not a read");

   a_pending_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      !do_tick |=> ((irq_pending_ff & ~$past(irq_pending_ff)) == '0))
      else $error("status bit set without a tick");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted item lost from input register");

endmodule

// ----- verif/dcrt_checker.sv -----
// Scoreboard for the dual channel reload timer: tracks the timer registers from the
// items taken on the req_ channel and compares every rsp_ item against them.
// Depends on dcrt_pkg.
`timescale 1ns / 100ps

module dcrt_checker import dcrt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,  // word_addr[3:0], write_data[35:4], pulse_fast[36],
                                   // pulse_slow[37], zero[39:38]
   input  logic [1:0]  req_tuser,  // kind[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,  // read_data[31:0], irq_line[32], zero[39:33]
   output int          mismatch_count,
   output int          outstanding,
   output int          checked_count,
   output int          expiry_count
);

   localparam int CHANNELS = NUM_CHANNELS_DEF;
   // reload and bit 3 are never stored
   localparam logic [7:0] CTL_STORED = 8'hF5;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq_line;
   } timer_result_type;

   logic [CHANNELS-1:0]   irq_enable;
   logic [CHANNELS-1:0]   irq_pending;
   logic [7:0]            control   [CHANNELS];
   logic [DATA_W-1:0]     interval  [CHANNELS];
   logic [DATA_W-1:0]     current   [CHANNELS];
   logic [PRESCALE_W-1:0] prescale  [CHANNELS];
   timer_result_type      expected_results[$];

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t dcrt_checker: %s", $time, msg);
   endtask

   task automatic tick_channel(input int c, input logic fast, input logic slow);
      logic [PRESCALE_W:0] wrap_at;
      wrap_at = (8'd1 << control[c][CTL_PRE_MSB:CTL_PRE_LSB]) - 8'd1;
      if (control[c][CTL_EN_BIT] && (control[c][CTL_FAST_BIT] ? fast : slow)) begin
         // a count left above a lowered limit wraps on the next pulse
         if ({1'b0, prescale[c]} < wrap_at) begin
            prescale[c] = prescale[c] + 1'b1;
         end else begin
            prescale[c] = '0;
            if (current[c] != '0) begin
               current[c] = current[c] - 1'b1;
            end else begin
               irq_pending[c] = 1'b1;
               expiry_count++;
               if (control[c][CTL_SINGLE_BIT])
                  control[c][CTL_EN_BIT] = 1'b0;
               else
                  current[c] = interval[c];
            end
         end
      end
   endtask

   task automatic execute_item(input kind_type kind, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data, input logic fast,
                               input logic slow, output timer_result_type res);
      int          c;
      logic [1:0]  slot;
      logic [1:0]  off;
      logic        mapped;
      slot = addr[3:2];
      off  = addr[1:0];
      c    = int'(slot) - 1;
      // slot 0 holds the shared interrupt registers, slot c+1 channel c
      mapped = (slot != 2'd0) && (c < CHANNELS) && (off != OFF_SPARE);
      res = '0;
      case (kind)
         KIND_TICK: begin
            for (int i = 0; i < CHANNELS; i++)
               tick_channel(i, fast, slow);
         end
         KIND_READ: begin
            if (addr == ADDR_IRQ_ENABLE)
               res.read_data = DATA_W'(irq_enable);
            else if (addr == ADDR_IRQ_STATUS)
               res.read_data = DATA_W'(irq_pending);
            else if (mapped) begin
               case (off)
                  OFF_CONTROL:  res.read_data = DATA_W'(control[c]);
                  OFF_INTERVAL: res.read_data = interval[c];
                  default:      res.read_data = current[c];
               endcase
            end
         end
         KIND_WRITE: begin
            if (addr == ADDR_IRQ_ENABLE)
               irq_enable = data[CHANNELS-1:0];
            else if (addr == ADDR_IRQ_STATUS)
               irq_pending = irq_pending & ~data[CHANNELS-1:0];
            else if (mapped) begin
               case (off)
                  OFF_CONTROL: begin
                     control[c] = data[7:0] & CTL_STORED;
                     if (data[CTL_RELOAD_BIT]) begin
                        current[c]  = interval[c];
                        prescale[c] = '0;
                     end
                  end
                  OFF_INTERVAL: interval[c] = data;
                  default:      current[c]  = data;
               endcase
            end
         end
         default: ;
      endcase
      res.irq_line = |(irq_pending & irq_enable);
   endtask

   always @(posedge clock) begin
      timer_result_type want;
      timer_result_type got;
      if (reset) begin
         irq_enable  = '0;
         irq_pending = '0;
         for (int i = 0; i < CHANNELS; i++) begin
            control[i]  = '0;
            interval[i] = '0;
            current[i]  = '0;
            prescale[i] = '0;
         end
         expected_results.delete();
      end else begin
         // results leave only after their item has passed the input and result registers, so check before predicting
         if (rsp_tvalid && rsp_tready) begin
            got.read_data = rsp_tdata[31:0];
            got.irq_line  = rsp_tdata[32];
            if (expected_results.size() == 0) begin
               flag_error($sformatf("result with none expected: read_data %h irq_line %b",
                                    got.read_data, got.irq_line));
            end else begin
               want = expected_results.pop_front();
               checked_count++;
               if (got.read_data !== want.read_data)
                  flag_error($sformatf("read_data expected %h got %h",
                                       want.read_data, got.read_data));
               if (got.irq_line !== want.irq_line)
                  flag_error($sformatf("irq_line expected %b got %b",
                                       want.irq_line, got.irq_line));
            end
         end
         if (req_tvalid && req_tready) begin
            execute_item(kind_type'(req_tuser), req_tdata[3:0], req_tdata[35:4],
                         req_tdata[36], req_tdata[37], want);
            expected_results.push_back(want);
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

// ----- verif/dual_channel_reload_timer_tb.sv -----
// Top of the dual channel reload timer testbench: clock, reset, item stimulus and
// result back-pressure, verdict. Depends on dcrt_pkg, dcrt_checker and the timer RTL.
`timescale 1ns / 100ps

module dual_channel_reload_timer_tb;
   import dcrt_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 6;
   localparam int RANDOM_ITEMS = 750;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = KIND_IDLE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   int mismatch_count;
   int outstanding;
   int checked_count;
   int expiry_count;
   int cycle_count = 0;
   int tick_items  = 0;
   int read_items  = 0;
   int write_items = 0;
   int idle_items  = 0;
   bit burst_mode  = 1'b0;
   bit hold_rsp    = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   dual_channel_reload_timer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   dcrt_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .checked_count  (checked_count),
      .expiry_count   (expiry_count)
   );

   // slot 0 is the shared registers, channel c sits in slot c+1
   function automatic logic [ADDR_W-1:0] reg_addr(input int c, input logic [1:0] off);
      return {2'(c + 1), off};
   endfunction

   function automatic bit is_mapped(input logic [ADDR_W-1:0] addr);
      if (addr[3:2] == 2'd0)
         return addr == ADDR_IRQ_ENABLE || addr == ADDR_IRQ_STATUS;
      return int'(addr[3:2]) - 1 < NUM_CHANNELS_DEF && addr[1:0] != OFF_SPARE;
   endfunction

   function automatic logic [DATA_W-1:0] ctl_word(input bit en, input bit reload,
                                                  input bit fast, input logic [2:0] pre,
                                                  input bit single);
      logic [DATA_W-1:0] w;
      w = '0;
      w[CTL_EN_BIT]                  = en;
      w[CTL_RELOAD_BIT]              = reload;
      w[CTL_FAST_BIT]                = fast;
      w[CTL_PRE_MSB:CTL_PRE_LSB]     = pre;
      w[CTL_SINGLE_BIT]              = single;
      return w;
   endfunction

   // called in the time step of a clock edge; returns at the edge that takes the item
   task automatic send_item(input kind_type kind, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data, input logic fast,
                            input logic slow);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, slow, fast, data, addr};
      do @(posedge clock); while (!req_tready);
      case (kind)
         KIND_TICK:  tick_items++;
         KIND_READ:  read_items++;
         KIND_WRITE: write_items++;
         default:    idle_items++;
      endcase
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // result side: random stall per item, one long hold on request
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = burst_mode ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, outstanding);
         $display("dual_channel_reload_timer_tb: FAIL");
         $finish;
      end
   end

   initial begin
      int                counted;
      int                r;
      int                c;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic              fast;
      logic              slow;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, both pulse sources, expiry in both modes, unmapped words
      send_item(KIND_READ,  ADDR_IRQ_ENABLE, '0, 1'b0, 1'b0);
      send_item(KIND_WRITE, ADDR_IRQ_ENABLE, '1, 1'b0, 1'b0);
      send_item(KIND_WRITE, reg_addr(0, OFF_INTERVAL), '1, 1'b0, 1'b0);
      send_item(KIND_WRITE, reg_addr(0, OFF_CONTROL), 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_item(KIND_READ,  reg_addr(0, OFF_CONTROL), '0, 1'b0, 1'b0);
      send_item(KIND_READ,  reg_addr(0, OFF_CURRENT), '0, 1'b0, 1'b0);
      send_item(KIND_WRITE, reg_addr(1, OFF_INTERVAL), 32'd1, 1'b0, 1'b0);
      send_item(KIND_WRITE, reg_addr(1, OFF_CONTROL),
                ctl_word(1'b1, 1'b1, 1'b0, 3'd0, 1'b0), 1'b0, 1'b0);
      send_item(KIND_TICK,  '0, '0, 1'b1, 1'b1);
      send_item(KIND_TICK,  '0, '0, 1'b0, 1'b1);
      send_item(KIND_READ,  ADDR_IRQ_STATUS, '0, 1'b0, 1'b0);
      send_item(KIND_WRITE, ADDR_IRQ_STATUS, 32'hFFFF_FFFC, 1'b0, 1'b0);
      send_item(KIND_WRITE, ADDR_IRQ_STATUS, '1, 1'b0, 1'b0);
      send_item(KIND_WRITE, reg_addr(0, OFF_CURRENT), '0, 1'b0, 1'b0);
      send_item(KIND_WRITE, reg_addr(0, OFF_CONTROL),
                ctl_word(1'b1, 1'b0, 1'b1, 3'd0, 1'b1), 1'b0, 1'b0);
      send_item(KIND_TICK,  '0, '0, 1'b1, 1'b0);
      send_item(KIND_READ,  reg_addr(0, OFF_CONTROL), '0, 1'b0, 1'b0);
      // lower the prescaler while its count is above the new limit
      send_item(KIND_WRITE, reg_addr(1, OFF_CONTROL),
                ctl_word(1'b1, 1'b0, 1'b0, 3'd3, 1'b0), 1'b0, 1'b0);
      send_item(KIND_TICK,  '0, '0, 1'b0, 1'b1);
      send_item(KIND_TICK,  '0, '0, 1'b0, 1'b1);
      send_item(KIND_WRITE, reg_addr(1, OFF_CONTROL),
                ctl_word(1'b1, 1'b0, 1'b0, 3'd1, 1'b0), 1'b0, 1'b0);
      send_item(KIND_TICK,  '0, '0, 1'b0, 1'b1);
      send_item(KIND_READ,  reg_addr(0, OFF_SPARE), '0, 1'b0, 1'b0);
      send_item(KIND_READ,  reg_addr(NUM_CHANNELS_DEF, OFF_CONTROL), '0, 1'b0, 1'b0);
      send_item(KIND_WRITE, ADDR_IRQ_STATUS + 1'b1, '1, 1'b0, 1'b0);
      send_item(KIND_IDLE,  '1, '1, 1'b1, 1'b1);
      drain_results();

      // random: mostly ticks against small intervals and prescalers so channels expire
      for (int phase = 0; phase < PHASES; phase++) begin
         burst_mode = (phase == 1 || phase == 4);
         if (phase == 2)
            hold_rsp = 1'b1;
         counted = 0;
         while (counted < RANDOM_ITEMS / PHASES) begin
            r    = $urandom_range(0, 99);
            c    = $urandom_range(0, NUM_CHANNELS_DEF - 1);
            addr = ADDR_W'($urandom_range(0, 15));
            data = $urandom;
            fast = 1'($urandom_range(0, 1));
            slow = 1'($urandom_range(0, 1));
            if (r < 55) begin
               send_item(KIND_TICK, addr, data, fast, slow);
               counted++;
            end else if (r < 70) begin
               data[CTL_PRE_MSB:CTL_PRE_LSB] = ($urandom_range(0, 7) == 0) ?
                                               3'($urandom_range(3, 7)) :
                                               3'($urandom_range(0, 2));
               data[CTL_EN_BIT] = ($urandom_range(0, 3) != 0);
               send_item(KIND_WRITE, reg_addr(c, OFF_CONTROL), data, fast, slow);
               counted++;
            end else if (r < 80) begin
               if ($urandom_range(0, 3) != 0)
                  data = $urandom_range(0, 6);
               send_item(KIND_WRITE, reg_addr(c, $urandom_range(0, 1) ? OFF_INTERVAL
                                                                       : OFF_CURRENT),
                         data, fast, slow);
               counted++;
            end else if (r < 85) begin
               send_item(KIND_WRITE, $urandom_range(0, 1) ? ADDR_IRQ_ENABLE : ADDR_IRQ_STATUS,
                         data, fast, slow);
               counted++;
            end else if (r < 97) begin
               send_item(KIND_READ, addr, data, fast, slow);
               counted++;
            end else if ($urandom_range(0, 1)) begin
               send_item(KIND_IDLE, addr, data, fast, slow);
            end else begin
               while (is_mapped(addr))
                  addr = ADDR_W'($urandom_range(0, 15));
               send_item(KIND_WRITE, addr, data, fast, slow);
            end
         end
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("items sent: %0d ticks, %0d reads, %0d writes, %0d of the unused kind",
               tick_items, read_items, write_items, idle_items);
      $display("%0d results compared, %0d channel expiries, %0d mismatches",
               checked_count, expiry_count, mismatch_count);
      if (mismatch_count == 0 && outstanding == 0)
         $display("dual_channel_reload_timer_tb: PASS");
      else
         $display("dual_channel_reload_timer_tb: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/dcrt_pkg.sv
rtl/dcrt_channel.sv
rtl/dual_channel_reload_timer.sv
verif/dcrt_checker.sv
verif/dual_channel_reload_timer_tb.sv
